@@ hw/rtl/bst_pkg.sv @@
// Shared types and codes for the byte stream tokenizer.
package bst_pkg;

  localparam int unsigned MAX_RUN_LENGTH = 255;
  localparam int unsigned RUN_LEN_W      = 8;
  localparam int unsigned INT_W          = 31;
  localparam int unsigned LINE_W         = 24;
  localparam int unsigned COL_W          = 16;
  localparam int unsigned QDEPTH         = 4;
  localparam int unsigned QPTR_W         = 2;
  localparam int unsigned QCNT_W         = 3;

  // Event codes of a result.
  localparam logic [3:0] EV_TEXT     = 4'd0;
  localparam logic [3:0] EV_INT_END  = 4'd1;
  localparam logic [3:0] EV_ID_END   = 4'd2;
  localparam logic [3:0] EV_OP_END   = 4'd3;
  localparam logic [3:0] EV_INDENT   = 4'd4;
  localparam logic [3:0] EV_NEWLINE  = 4'd5;
  localparam logic [3:0] EV_BAD_BYTE = 4'd6;
  localparam logic [3:0] EV_TOO_LONG = 4'd7;
  localparam logic [3:0] EV_END      = 4'd8;

  // Run mode codes.
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_INT   = 3'd1;
  localparam logic [2:0] MODE_IDENT = 3'd2;
  localparam logic [2:0] MODE_OP    = 3'd3;
  localparam logic [2:0] MODE_EBAD  = 3'd4;
  localparam logic [2:0] MODE_ELONG = 3'd5;

  // Input action codes.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] char_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]        event_res;
    logic [7:0]        text_char;
    logic [INT_W-1:0]  int_value;
    logic              int_saturated;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column_number;
    logic              last;
  } out_t;

endpackage

@@ hw/rtl/byte_stream_tokenizer_top.sv @@
// Byte stream tokenizer: character-class lexer with a four-entry result queue.
// Each result is registered in the result queue when its item is accepted and waits behind any held results.
// Throughput: one item per cycle while src_ready is high; an item giving two results takes two
// queue entries, and src_ready drops while the result queue holds
// more than two results.
// Reset (rst, synchronous) clears the lexer state, sets line and column to one
// and empties the result queue.
module byte_stream_tokenizer_top
  import bst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic src_valid,
  output logic src_ready,
  input  in_t  src_data,
  output logic res_valid,
  input  logic res_ready,
  output out_t res_data
);

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UNDER   = "_";

  // Lexer state.
  logic [2:0]           run_mode;
  logic                 space_pending;
  logic [INT_W-1:0]     number_accumulator;
  logic                 number_saturated;
  logic [RUN_LEN_W-1:0] run_length;
  logic [LINE_W-1:0]    line_count;
  logic [COL_W-1:0]     column_count;
  logic                 error_latched;

  logic [2:0]           run_mode_next;
  logic                 space_pending_next;
  logic [INT_W-1:0]     number_accumulator_next;
  logic                 number_saturated_next;
  logic [RUN_LEN_W-1:0] run_length_next;
  logic [LINE_W-1:0]    line_count_next;
  logic [COL_W-1:0]     column_count_next;
  logic                 error_latched_next;

  out_t       res0;
  out_t       res1;
  logic [1:0] res_count;

  // Result queue.
  out_t              queue [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QCNT_W-1:0] count;

  logic src_acc;
  logic res_acc;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == "!") || (c == "|") || (c == "%") || (c == "&") || (c == "+") ||
           (c == "-") || (c == "*") || (c == "/") || (c == ".") || (c == ":") ||
           (c == "=") || (c == "<") || (c == ">");
  endfunction

  function automatic logic is_id_first(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
  endfunction

  function automatic out_t mk(input logic [3:0] ev, input logic [7:0] ch,
                              input logic [INT_W-1:0] val, input logic sat,
                              input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] col);
    out_t r;
    r.event_res     = ev;
    r.text_char     = ch;
    r.int_value     = val;
    r.int_saturated = sat;
    r.line_number   = ln;
    r.column_number = col;
    r.last          = 1'b0;
    return r;
  endfunction

  assign src_ready = (count < QCNT_W'(QDEPTH - 1));
  assign src_acc   = src_valid & src_ready;
  assign res_valid = (count != '0);
  assign res_acc   = res_valid & res_ready;
  assign res_data  = queue[head];

  always_comb begin
    logic [7:0]       c;
    logic             cont;
    logic [INT_W+3:0] prod;
    logic [3:0]       evc;
    out_t             r;

    c    = src_data.char_byte;
    cont = 1'b0;
    prod = '0;
    evc  = EV_END;
    r    = '0;

    run_mode_next           = run_mode;
    space_pending_next      = space_pending;
    number_accumulator_next = number_accumulator;
    number_saturated_next   = number_saturated;
    run_length_next         = run_length;
    line_count_next         = line_count;
    column_count_next       = column_count;
    error_latched_next      = error_latched;
    res0      = '0;
    res1      = '0;
    res_count = 2'd0;

    if (error_latched) begin
      res0 = mk((run_mode == MODE_ELONG) ? EV_TOO_LONG : EV_BAD_BYTE, 8'd0, '0, 1'b0,
                line_count, column_count);
      res_count = 2'd1;
    end else begin
      if (src_data.action == ACT_BYTE) begin
        if (c == CH_NEWLINE) begin
          if (line_count != '1) line_count_next = line_count + 1'b1;
          column_count_next = COL_W'(1);
        end else if (column_count != '1) begin
          column_count_next = column_count + 1'b1;
        end
        cont = ((run_mode == MODE_INT) && is_digit(c)) ||
               ((run_mode == MODE_IDENT) && (is_id_first(c) || is_digit(c))) ||
               ((run_mode == MODE_OP) && is_op(c));
      end

      if ((src_data.action == ACT_BYTE) && cont) begin
        if (run_length >= RUN_LEN_W'(MAX_RUN_LENGTH)) begin
          error_latched_next = 1'b1;
          run_mode_next      = MODE_ELONG;
          res0 = mk(EV_TOO_LONG, 8'd0, '0, 1'b0, line_count_next, column_count_next);
          res_count = 2'd1;
        end else begin
          run_length_next = run_length + 1'b1;
          if (run_mode == MODE_INT) begin
            if (!number_saturated) begin
              // acc * 10 as (acc << 3) + (acc << 1), plus the digit.
              prod = {1'b0, number_accumulator, 3'b000} +
                     {3'b000, number_accumulator, 1'b0} +
                     (INT_W+4)'(c[3:0]);
              if (prod[INT_W+3:INT_W] != '0) begin
                number_saturated_next   = 1'b1;
                number_accumulator_next = '1;
              end else begin
                number_accumulator_next = prod[INT_W-1:0];
              end
            end
          end else begin
            res0 = mk(EV_TEXT, c, '0, 1'b0, line_count_next, column_count_next);
            res_count = 2'd1;
          end
        end
      end else begin
        // Close any open run first.
        unique case (run_mode)
          MODE_INT: begin
            res0 = mk(EV_INT_END, 8'd0, number_accumulator, number_saturated,
                      line_count_next, column_count_next);
            res_count = 2'd1;
          end
          MODE_IDENT: begin
            res0 = mk(EV_ID_END, 8'd0, '0, 1'b0, line_count_next, column_count_next);
            res_count = 2'd1;
          end
          MODE_OP: begin
            res0 = mk(EV_OP_END, 8'd0, '0, 1'b0, line_count_next, column_count_next);
            res_count = 2'd1;
          end
          default: ;
        endcase
        run_mode_next   = MODE_IDLE;
        run_length_next = '0;

        // Then handle the item as a fresh byte or as end of input.
        cont = 1'b0;
        if (src_data.action == ACT_END) begin
          space_pending_next = 1'b0;
          evc  = EV_END;
          cont = 1'b1;
        end else if (c == CH_SPACE) begin
          space_pending_next = ~space_pending;
          evc  = EV_INDENT;
          cont = space_pending;
        end else begin
          space_pending_next = 1'b0;
          if (is_digit(c)) begin
            run_mode_next           = MODE_INT;
            number_accumulator_next = INT_W'(c[3:0]);
            number_saturated_next   = 1'b0;
            run_length_next         = RUN_LEN_W'(1);
          end else if (is_op(c)) begin
            run_mode_next   = MODE_OP;
            run_length_next = RUN_LEN_W'(1);
            evc  = EV_TEXT;
            cont = 1'b1;
          end else if (is_id_first(c)) begin
            run_mode_next   = MODE_IDENT;
            run_length_next = RUN_LEN_W'(1);
            evc  = EV_TEXT;
            cont = 1'b1;
          end else if (c == CH_NEWLINE) begin
            evc  = EV_NEWLINE;
            cont = 1'b1;
          end else begin
            error_latched_next = 1'b1;
            run_mode_next      = MODE_EBAD;
            evc  = EV_BAD_BYTE;
            cont = 1'b1;
          end
        end

        if (cont) begin
          r = mk(evc, (evc == EV_TEXT) ? c : 8'd0, '0, 1'b0,
                 line_count_next, column_count_next);
          if (res_count == 2'd0) begin
            res0 = r;
          end else begin
            res1 = r;
          end
          res_count = res_count + 2'd1;
        end
      end
    end

    if (res_count == 2'd1) res0.last = 1'b1;
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode           <= MODE_IDLE;
      space_pending      <= 1'b0;
      number_accumulator <= '0;
      number_saturated   <= 1'b0;
      run_length         <= '0;
      line_count         <= LINE_W'(1);
      column_count       <= COL_W'(1);
      error_latched      <= 1'b0;
    end else if (src_acc) begin
      run_mode           <= run_mode_next;
      space_pending      <= space_pending_next;
      number_accumulator <= number_accumulator_next;
      number_saturated   <= number_saturated_next;
      run_length         <= run_length_next;
      line_count         <= line_count_next;
      column_count       <= column_count_next;
      error_latched      <= error_latched_next;
    end
  end

  // Result queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (res_acc) head <= head + 1'b1;
      count <= count + (src_acc ? QCNT_W'(res_count) : '0) - QCNT_W'(res_acc);
    end
  end

  // Results are written behind the entries already held.
  always_ff @(posedge clk) begin
    if (src_acc && (res_count != 2'd0)) begin
      queue[head + count[QPTR_W-1:0]] <= res0;
    end
    if (src_acc && (res_count == 2'd2)) begin
      queue[head + count[QPTR_W-1:0] + 1'b1] <= res1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("latched error cleared without reset");

  a_error_one_result: assert property (@(posedge clk) disable iff (rst)
    (src_acc && error_latched) |-> (res_count == 2'd1))
    else $error("latched error must give exactly one result");

  a_counters_nonzero: assert property (@(posedge clk) disable iff (rst)
    (line_count != '0) && (column_count != '0))
    else $error("line or column counter reached zero");

endmodule
